/* design/bpk_pkg.sv */
package bpk_pkg;

   // word geometry
   localparam int WORD_BITS  = 32;
   localparam int FIELD_BITS = 64;
   localparam int COUNT_BITS = 7;
   localparam int HCNT_BITS  = $clog2(WORD_BITS);
   localparam int WBITS_W    = HCNT_BITS + 1;
   localparam int CAT_BITS   = WORD_BITS + FIELD_BITS - 1;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_FLUSH = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   // one result transaction
   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [WBITS_W-1:0]   bits;
      logic                 last;
   } rsp_item_type;

   // results produced by one input transaction
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

/* design/lsb_first_bit_packer.sv */
// channel   direction  handshake            payload
// req       in         req_valid/req_ready  req_op, req_field_value, req_bit_count
// rsp       out        rsp_valid/rsp_ready  rsp_packed_word, rsp_word_bits, rsp_last_of_run
//
// One request per cycle is taken while req_ready is high; it sits in the input
// register, where the pack logic updates the holding word and queues 0 to 2 words.
// Responses leave one per cycle while rsp_ready is high, from a 4-entry queue, so
// writes that emit two words are throttled by the single response port.
// Reset is synchronous and clears the holding word and the queue.
// req_ready drops only while the queue has fewer than two free entries.
module lsb_first_bit_packer import bpk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [FIELD_BITS-1:0] req_field_value,
   input  logic [COUNT_BITS-1:0] req_bit_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_BITS-1:0]  rsp_packed_word,
   output logic [WBITS_W-1:0]    rsp_word_bits,
   output logic                  rsp_last_of_run
);

   push_type     push;
   logic         room;
   rsp_item_type rsp_item;

   // packing stage
   bpk_pack_core u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_field_value (req_field_value),
      .req_bit_count   (req_bit_count),
      .room            (room),
      .push            (push)
   );

   // response queue
   bpk_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_packed_word = rsp_item.word;
   assign rsp_word_bits   = rsp_item.bits;
   assign rsp_last_of_run = rsp_item.last;

endmodule

/* design/bpk_pack_core.sv */
module bpk_pack_core import bpk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [FIELD_BITS-1:0] req_field_value,
   input  logic [COUNT_BITS-1:0] req_bit_count,
   input  logic                  room,
   output push_type              push
);

   logic                  s1_valid_ff;
   logic [1:0]            s1_op_ff;
   logic [FIELD_BITS-1:0] s1_value_ff;
   logic [COUNT_BITS-1:0] s1_count_ff;
   logic [WORD_BITS-1:0]  hold_bits_ff, hold_bits_in;
   logic [HCNT_BITS-1:0]  hold_count_ff, hold_count_in;

   logic                  advance;
   logic                  wr_ok;
   logic [FIELD_BITS-1:0] val_masked;
   logic [CAT_BITS-1:0]   combined;
   logic [COUNT_BITS-1:0] total;
   logic [1:0]            nwords;

   // staged item moves on when the output queue has room for two words
   assign advance   = s1_valid_ff && room;
   assign req_ready = !s1_valid_ff || room;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_op_ff    <= req_op;
         s1_value_ff <= req_field_value;
         s1_count_ff <= req_bit_count;
      end
   end

   // append the new field above the held bits
   always_comb begin
      wr_ok = (s1_op_ff == OP_WRITE) && (s1_count_ff != '0)
              && (s1_count_ff <= COUNT_BITS'(FIELD_BITS));
      if (s1_count_ff >= COUNT_BITS'(FIELD_BITS)) begin
         val_masked = s1_value_ff;
      end else begin
         val_masked = s1_value_ff & ((FIELD_BITS'(1) << s1_count_ff) - FIELD_BITS'(1));
      end
      combined = CAT_BITS'(hold_bits_ff) | (CAT_BITS'(val_masked) << hold_count_ff);
      total    = COUNT_BITS'(hold_count_ff) + s1_count_ff;
      nwords   = total[COUNT_BITS-1:HCNT_BITS];
   end

   // next hold state and results
   always_comb begin
      hold_bits_in  = hold_bits_ff;
      hold_count_in = hold_count_ff;
      push          = '0;
      push.item0.word = combined[WORD_BITS-1:0];
      push.item0.bits = WBITS_W'(WORD_BITS);
      push.item0.last = (nwords == 2'd1);
      push.item1.word = combined[2*WORD_BITS-1:WORD_BITS];
      push.item1.bits = WBITS_W'(WORD_BITS);
      push.item1.last = 1'b1;
      if (advance) begin
         case (s1_op_ff)
            OP_RESET: begin
               hold_bits_in  = '0;
               hold_count_in = '0;
            end
            OP_FLUSH: begin
               if (hold_count_ff != '0) begin
                  push.count      = 2'd1;
                  push.item0.word = hold_bits_ff;
                  push.item0.bits = WBITS_W'(hold_count_ff);
                  push.item0.last = 1'b1;
                  hold_bits_in    = '0;
                  hold_count_in   = '0;
               end
            end
            OP_WRITE: begin
               if (wr_ok) begin
                  push.count    = nwords;
                  hold_count_in = total[HCNT_BITS-1:0];
                  case (nwords)
                     2'd0:    hold_bits_in = combined[WORD_BITS-1:0];
                     2'd1:    hold_bits_in = combined[2*WORD_BITS-1:WORD_BITS];
                     default: hold_bits_in = WORD_BITS'(combined[CAT_BITS-1:2*WORD_BITS]);
                  endcase
               end
            end
            default: begin
               // unused op code: no effect
            end
         endcase
      end
   end

   // holding register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_bits_ff  <= '0;
         hold_count_ff <= '0;
      end else begin
         hold_bits_ff  <= hold_bits_in;
         hold_count_ff <= hold_count_in;
      end
   end

endmodule

/* design/bpk_out_fifo.sv */
module bpk_out_fifo import bpk_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   rsp_item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]       count_ff;
   logic                 pop;

   assign room      = count_ff <= (PTR_W+1)'(DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // storage: up to two writes per cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.item1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(push.count);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
      end
   end

endmodule
